>>> src/epm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Equirectangular pixel map package
// Shared field widths, register indexes and the pipeline sideband type.
// ----------------------------------------------------------------------------
package epm_pkg;

   localparam int LON_W      = 25;
   localparam int LAT_W      = 24;
   localparam int PIX_W      = 17;
   localparam int DIM_W      = 15;
   localparam int LON_OUT_W  = 26;
   localparam int LAT_OUT_W  = 25;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 25;

   typedef logic [CSR_IDX_W-1:0] csr_index_type;

   localparam csr_index_type CSR_IMAGE_WIDTH      = 3'd0;
   localparam csr_index_type CSR_IMAGE_HEIGHT     = 3'd1;
   localparam csr_index_type CSR_TOP_LEFT_LON     = 3'd2;
   localparam csr_index_type CSR_TOP_LEFT_LAT     = 3'd3;
   localparam csr_index_type CSR_BOTTOM_RIGHT_LON = 3'd4;
   localparam csr_index_type CSR_BOTTOM_RIGHT_LAT = 3'd5;

   localparam logic OP_FORWARD = 1'b0;
   localparam logic OP_REVERSE = 1'b1;

   // vld: request present; reject: early range failure
   // sx/sy: product sign; satx/saty: forward quotient overflow; zx/zy: zero product
   typedef struct packed {
      logic vld;
      logic op;
      logic oob;
      logic reject;
      logic sx;
      logic sy;
      logic satx;
      logic saty;
      logic zx;
      logic zy;
   } side_type;

endpackage

>>> src/epm_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Equirectangular pixel map divider cell
// One quotient bit for both axes; remainder, quotient and divisor move on
// to the next cell every enabled cycle.
// ----------------------------------------------------------------------------
module epm_cell #(
   parameter int PW    = 42,
   parameter int DW    = 26,
   parameter int QN    = 26,
   parameter int SHIFT = 0
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  epm_pkg::side_type  up_side,
   input  logic [PW-1:0]      up_rem_x,
   input  logic [PW-1:0]      up_rem_y,
   input  logic [QN-1:0]      up_q_x,
   input  logic [QN-1:0]      up_q_y,
   input  logic [DW-1:0]      up_d_x,
   input  logic [DW-1:0]      up_d_y,
   output epm_pkg::side_type  dn_side,
   output logic [PW-1:0]      dn_rem_x,
   output logic [PW-1:0]      dn_rem_y,
   output logic [QN-1:0]      dn_q_x,
   output logic [QN-1:0]      dn_q_y,
   output logic [DW-1:0]      dn_d_x,
   output logic [DW-1:0]      dn_d_y
);

   epm_pkg::side_type side_ff;
   logic [PW-1:0]     rem_x_ff, rem_y_ff, rem_x_in, rem_y_in;
   logic [QN-1:0]     q_x_ff, q_y_ff, q_x_in, q_y_in;
   logic [DW-1:0]     d_x_ff, d_y_ff;
   logic              take_x, take_y;

   always_comb begin
      take_x   = (up_rem_x >> SHIFT) >= PW'(up_d_x);
      take_y   = (up_rem_y >> SHIFT) >= PW'(up_d_y);
      rem_x_in = take_x ? up_rem_x - (PW'(up_d_x) << SHIFT) : up_rem_x;
      rem_y_in = take_y ? up_rem_y - (PW'(up_d_y) << SHIFT) : up_rem_y;
      q_x_in   = up_q_x;
      q_y_in   = up_q_y;
      q_x_in[SHIFT] = take_x;
      q_y_in[SHIFT] = take_y;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         side_ff <= '0;
      end else if (en) begin
         side_ff <= up_side;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_x_ff <= rem_x_in;
         rem_y_ff <= rem_y_in;
         q_x_ff   <= q_x_in;
         q_y_ff   <= q_y_in;
         d_x_ff   <= up_d_x;
         d_y_ff   <= up_d_y;
      end
   end

   assign dn_side  = side_ff;
   assign dn_rem_x = rem_x_ff;
   assign dn_rem_y = rem_y_ff;
   assign dn_q_x   = q_x_ff;
   assign dn_q_y   = q_y_ff;
   assign dn_d_x   = d_x_ff;
   assign dn_d_y   = d_y_ff;

endmodule

>>> src/equirectangular_pixel_map_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Equirectangular pixel map
// Longitude/latitude to pixel and pixel to longitude/latitude for an image
// whose corners and size are held in configuration registers.
// ----------------------------------------------------------------------------
// Takes one request per clock while no result waits on rsp_ready, and gives
// one result per request. Each request passes the capture, operand and
// product stages, then the row of divider cells that resolves one quotient
// bit per cell for both axes, then the output register.
// The whole pipeline holds while a result waits on rsp_ready. Configuration
// must only be written while no request is in flight.
module equirectangular_pixel_map_top #(
   parameter int COORD_FRAC_BITS = 16,
   parameter int MAX_IMAGE_DIM   = 16384
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic                                   req_op,
   input  logic signed [epm_pkg::LON_W-1:0]       req_lon_in,
   input  logic signed [epm_pkg::LAT_W-1:0]       req_lat_in,
   input  logic signed [epm_pkg::PIX_W-1:0]       req_pixel_x_in,
   input  logic signed [epm_pkg::PIX_W-1:0]       req_pixel_y_in,
   input  logic                                   req_allow_out_of_bounds,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic signed [epm_pkg::PIX_W-1:0]       rsp_pixel_x_out,
   output logic signed [epm_pkg::PIX_W-1:0]       rsp_pixel_y_out,
   output logic signed [epm_pkg::LON_OUT_W-1:0]   rsp_lon_out,
   output logic signed [epm_pkg::LAT_OUT_W-1:0]   rsp_lat_out,
   output logic                                   rsp_valid_res,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  epm_pkg::csr_index_type                 csr_index,
   input  logic [epm_pkg::CSR_DATA_W-1:0]         csr_data
);

   localparam int AW    = (COORD_FRAC_BITS + 10 > 27) ? COORD_FRAC_BITS + 10 : 27;
   localparam int DW    = AW - 1;
   localparam int PW    = AW + epm_pkg::DIM_W;
   localparam int QN    = AW - 1;
   localparam int PIX_W = epm_pkg::PIX_W;
   localparam int DIM_W = epm_pkg::DIM_W;

   localparam longint DEG90_I  = 90 * (longint'(1) << COORD_FRAC_BITS);
   localparam longint DEG180_I = 180 * (longint'(1) << COORD_FRAC_BITS);
   localparam longint REJ_I    = -(longint'(1) << COORD_FRAC_BITS);
   localparam logic signed [AW-1:0] DEG90  = AW'(DEG90_I);
   localparam logic signed [AW-1:0] DEG180 = AW'(DEG180_I);
   localparam logic [DIM_W-1:0] MAX_DIM =
      (MAX_IMAGE_DIM >= (1 << DIM_W)) ? {DIM_W{1'b1}} : DIM_W'(MAX_IMAGE_DIM);
   localparam logic [QN-1:0] QPOS_MAX = QN'((1 << (PIX_W - 1)) - 1);
   localparam logic [QN-1:0] QNEG_MAX = QN'(1 << (PIX_W - 1));
   localparam logic signed [PIX_W-1:0] PIX_MAX = PIX_W'((1 << (PIX_W - 1)) - 1);
   localparam logic signed [PIX_W-1:0] PIX_MIN = PIX_W'(-(1 << (PIX_W - 1)));
   localparam logic signed [PIX_W-1:0] PIX_REJ = PIX_W'(-1);

   // configuration registers
   logic [DIM_W-1:0]                     width_ff, height_ff;
   logic signed [epm_pkg::LON_W-1:0]     tlon_ff, blon_ff;
   logic signed [epm_pkg::LAT_W-1:0]     tlat_ff, blat_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= DIM_W'(1);
         height_ff <= DIM_W'(1);
         tlon_ff   <= epm_pkg::LON_W'(-DEG180_I);
         tlat_ff   <= epm_pkg::LAT_W'(DEG90_I);
         blon_ff   <= epm_pkg::LON_W'(DEG180_I);
         blat_ff   <= epm_pkg::LAT_W'(-DEG90_I);
      end else if (csr_valid) begin
         unique case (csr_index)
            epm_pkg::CSR_IMAGE_WIDTH:      width_ff  <= csr_data[DIM_W-1:0];
            epm_pkg::CSR_IMAGE_HEIGHT:     height_ff <= csr_data[DIM_W-1:0];
            epm_pkg::CSR_TOP_LEFT_LON:     tlon_ff   <= csr_data[epm_pkg::LON_W-1:0];
            epm_pkg::CSR_TOP_LEFT_LAT:     tlat_ff   <= csr_data[epm_pkg::LAT_W-1:0];
            epm_pkg::CSR_BOTTOM_RIGHT_LON: blon_ff   <= csr_data[epm_pkg::LON_W-1:0];
            epm_pkg::CSR_BOTTOM_RIGHT_LAT: blat_ff   <= csr_data[epm_pkg::LAT_W-1:0];
            default: ;
         endcase
      end
   end

   assign csr_ready = 1'b1;

   // derived spans, offsets and clamped sizes
   logic signed [AW-1:0] tlon_e, blon_e, tlat_e, blat_e;
   logic signed [AW-1:0] cov_lat_d, cov_lon_d, off_lat_d, off_lon_d;
   logic [DW-1:0]        cov_lat_ff, cov_lon_ff;
   logic signed [AW-1:0] off_lat_ff, off_lon_ff;
   logic [DIM_W-1:0]     w_ff, h_ff;
   logic signed [AW-1:0] w_e, h_e;

   assign tlon_e = AW'(tlon_ff);
   assign blon_e = AW'(blon_ff);
   assign tlat_e = AW'(tlat_ff);
   assign blat_e = AW'(blat_ff);

   always_comb begin
      cov_lat_d = tlat_e - blat_e;
      cov_lon_d = tlon_e - blon_e;
      off_lat_d = tlat_e - DEG90;
      off_lon_d = tlon_e + DEG180;
   end

   always_ff @(posedge clock) begin
      cov_lat_ff <= DW'(cov_lat_d[AW-1] ? -cov_lat_d : cov_lat_d);
      cov_lon_ff <= DW'(cov_lon_d[AW-1] ? -cov_lon_d : cov_lon_d);
      off_lat_ff <= off_lat_d[AW-1] ? -off_lat_d : off_lat_d;
      off_lon_ff <= off_lon_d[AW-1] ? -off_lon_d : off_lon_d;
      w_ff       <= (width_ff > MAX_DIM) ? MAX_DIM : width_ff;
      h_ff       <= (height_ff > MAX_DIM) ? MAX_DIM : height_ff;
   end

   assign w_e = $signed(AW'(w_ff));
   assign h_e = $signed(AW'(h_ff));

   logic en;
   logic rsp_valid_ff;
   assign en        = !rsp_valid_ff || rsp_ready;
   assign req_ready = en;

   // stage 1: request capture
   epm_pkg::side_type                s1_side_ff, s1_side_in;
   logic signed [epm_pkg::LON_W-1:0] s1_lon_ff;
   logic signed [epm_pkg::LAT_W-1:0] s1_lat_ff;
   logic signed [PIX_W-1:0]          s1_px_ff, s1_py_ff;

   assign s1_side_in = '{vld: req_valid, op: req_op, oob: req_allow_out_of_bounds,
                         default: 1'b0};

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_side_ff <= '0;
      end else if (en) begin
         s1_side_ff <= s1_side_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_lon_ff <= req_lon_in;
         s1_lat_ff <= req_lat_in;
         s1_px_ff  <= req_pixel_x_in;
         s1_py_ff  <= req_pixel_y_in;
      end
   end

   // stage 2: multiplier operands and early checks
   logic signed [AW-1:0] lon_e, lat_e, px_e, py_e, nx, ny;
   logic                 box_fail, pix_fail;
   epm_pkg::side_type    s2_side_ff, s2_side_in;
   logic signed [AW-1:0] s2_ax_ff, s2_bx_ff, s2_ay_ff, s2_by_ff;
   logic [DW-1:0]        s2_dx_ff, s2_dy_ff;

   always_comb begin
      lon_e    = AW'(s1_lon_ff);
      lat_e    = AW'(s1_lat_ff);
      px_e     = AW'(s1_px_ff);
      py_e     = AW'(s1_py_ff);
      ny       = DEG90 - lat_e - off_lat_ff;
      nx       = lon_e + DEG180 - off_lon_ff;
      box_fail = lat_e > tlat_e || lat_e < blat_e || lon_e < tlon_e || lon_e > blon_e;
      pix_fail = py_e < 0 || py_e >= h_e || px_e < 0 || px_e >= w_e;
      s2_side_in        = s1_side_ff;
      s2_side_in.reject = (s1_side_ff.op == epm_pkg::OP_REVERSE) ? pix_fail
                                                                 : (!s1_side_ff.oob && box_fail);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_side_ff <= '0;
      end else if (en) begin
         s2_side_ff <= s2_side_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         if (s1_side_ff.op == epm_pkg::OP_REVERSE) begin
            s2_ax_ff <= px_e;
            s2_bx_ff <= $signed(AW'(cov_lon_ff));
            s2_dx_ff <= DW'(w_ff);
            s2_ay_ff <= py_e;
            s2_by_ff <= $signed(AW'(cov_lat_ff));
            s2_dy_ff <= DW'(h_ff);
         end else begin
            s2_ax_ff <= nx;
            s2_bx_ff <= w_e;
            s2_dx_ff <= cov_lon_ff;
            s2_ay_ff <= ny;
            s2_by_ff <= h_e;
            s2_dy_ff <= cov_lat_ff;
         end
      end
   end

   // stage 3: products
   logic signed [2*AW-1:0] prod_x, prod_y;
   epm_pkg::side_type      s3_side_ff;
   logic signed [PW-1:0]   s3_px_ff, s3_py_ff;
   logic [DW-1:0]          s3_dx_ff, s3_dy_ff;

   assign prod_x = s2_ax_ff * s2_bx_ff;
   assign prod_y = s2_ay_ff * s2_by_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_side_ff <= '0;
      end else if (en) begin
         s3_side_ff <= s2_side_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s3_px_ff <= prod_x[PW-1:0];
         s3_py_ff <= prod_y[PW-1:0];
         s3_dx_ff <= s2_dx_ff;
         s3_dy_ff <= s2_dy_ff;
      end
   end

   // magnitude and forward overflow check feed the divider row
   logic [PW-1:0]     mag_x, mag_y;
   epm_pkg::side_type front_side;
   epm_pkg::side_type cell_side [QN+1];
   logic [PW-1:0]     cell_rem_x [QN+1];
   logic [PW-1:0]     cell_rem_y [QN+1];
   logic [QN-1:0]     cell_q_x [QN+1];
   logic [QN-1:0]     cell_q_y [QN+1];
   logic [DW-1:0]     cell_d_x [QN+1];
   logic [DW-1:0]     cell_d_y [QN+1];

   always_comb begin
      mag_x = s3_px_ff[PW-1] ? PW'(-s3_px_ff) : PW'(s3_px_ff);
      mag_y = s3_py_ff[PW-1] ? PW'(-s3_py_ff) : PW'(s3_py_ff);
      front_side      = s3_side_ff;
      front_side.sx   = s3_px_ff[PW-1];
      front_side.sy   = s3_py_ff[PW-1];
      front_side.zx   = mag_x == '0;
      front_side.zy   = mag_y == '0;
      front_side.satx = s3_side_ff.op == epm_pkg::OP_FORWARD && mag_x != '0
                        && (mag_x >> (PIX_W + 1)) >= PW'(s3_dx_ff);
      front_side.saty = s3_side_ff.op == epm_pkg::OP_FORWARD && mag_y != '0
                        && (mag_y >> (PIX_W + 1)) >= PW'(s3_dy_ff);
   end

   assign cell_side[0]  = front_side;
   assign cell_rem_x[0] = mag_x;
   assign cell_rem_y[0] = mag_y;
   assign cell_q_x[0]   = '0;
   assign cell_q_y[0]   = '0;
   assign cell_d_x[0]   = s3_dx_ff;
   assign cell_d_y[0]   = s3_dy_ff;

   for (genvar k = 0; k < QN; k++) begin : g_cell
      epm_cell #(
         .PW    (PW),
         .DW    (DW),
         .QN    (QN),
         .SHIFT (QN - 1 - k)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .en       (en),
         .up_side  (cell_side[k]),
         .up_rem_x (cell_rem_x[k]),
         .up_rem_y (cell_rem_y[k]),
         .up_q_x   (cell_q_x[k]),
         .up_q_y   (cell_q_y[k]),
         .up_d_x   (cell_d_x[k]),
         .up_d_y   (cell_d_y[k]),
         .dn_side  (cell_side[k+1]),
         .dn_rem_x (cell_rem_x[k+1]),
         .dn_rem_y (cell_rem_y[k+1]),
         .dn_q_x   (cell_q_x[k+1]),
         .dn_q_y   (cell_q_y[k+1]),
         .dn_d_x   (cell_d_x[k+1]),
         .dn_d_y   (cell_d_y[k+1])
      );
   end

   // result assembly
   function automatic logic signed [PIX_W-1:0] fwd_pix(
      input logic [QN-1:0] q, input logic s, input logic sat, input logic z);
      logic signed [PIX_W-1:0] r;
      if (z) begin
         r = '0;
      end else if (!s) begin
         r = (sat || q > QPOS_MAX) ? PIX_MAX : $signed(q[PIX_W-1:0]);
      end else begin
         r = (sat || q > QNEG_MAX) ? PIX_MIN : -$signed(q[PIX_W-1:0]);
      end
      return r;
   endfunction

   epm_pkg::side_type       fs;
   logic signed [PIX_W-1:0] rx, ry;
   logic signed [AW-1:0]    la, lo;
   logic                    fwd_fail, rev_fail, ok;
   logic signed [PIX_W-1:0]             px_in, py_in;
   logic signed [epm_pkg::LON_OUT_W-1:0] lon_in;
   logic signed [epm_pkg::LAT_OUT_W-1:0] lat_in;
   logic signed [PIX_W-1:0]             px_ff, py_ff;
   logic signed [epm_pkg::LON_OUT_W-1:0] lon_ff;
   logic signed [epm_pkg::LAT_OUT_W-1:0] lat_ff;
   logic                                ok_ff;

   always_comb begin
      fs = cell_side[QN];
      rx = fwd_pix(cell_q_x[QN], fs.sx, fs.satx, fs.zx);
      ry = fwd_pix(cell_q_y[QN], fs.sy, fs.saty, fs.zy);
      la = DEG90 - ($signed(AW'(cell_q_y[QN])) + off_lat_ff);
      lo = $signed(AW'(cell_q_x[QN])) + off_lon_ff - DEG180;
      fwd_fail = !fs.oob && (ry < 0 || AW'(ry) >= h_e || rx < 0 || AW'(rx) >= w_e);
      rev_fail = la > tlat_e || la < blat_e || lo < tlon_e || lo > blon_e;
      px_in  = '0;
      py_in  = '0;
      lon_in = '0;
      lat_in = '0;
      if (fs.op == epm_pkg::OP_FORWARD) begin
         ok    = !fs.reject && !fwd_fail;
         px_in = ok ? rx : PIX_REJ;
         py_in = ok ? ry : PIX_REJ;
      end else begin
         ok     = !fs.reject && !rev_fail;
         lon_in = ok ? epm_pkg::LON_OUT_W'(lo) : epm_pkg::LON_OUT_W'(REJ_I);
         lat_in = ok ? epm_pkg::LAT_OUT_W'(la) : epm_pkg::LAT_OUT_W'(REJ_I);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= fs.vld;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         px_ff  <= px_in;
         py_ff  <= py_in;
         lon_ff <= lon_in;
         lat_ff <= lat_in;
         ok_ff  <= ok;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pixel_x_out = px_ff;
   assign rsp_pixel_y_out = py_ff;
   assign rsp_lon_out     = lon_ff;
   assign rsp_lat_out     = lat_ff;
   assign rsp_valid_res   = ok_ff;

endmodule

>>> src/epm_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Equirectangular pixel map checker
// Port-level properties of the mapping block, bound to the top level.
// ----------------------------------------------------------------------------
module epm_checker #(
   parameter int COORD_FRAC_BITS = 16
) (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_ready,
   input logic                                 rsp_valid,
   input logic                                 rsp_ready,
   input logic signed [epm_pkg::PIX_W-1:0]     rsp_pixel_x_out,
   input logic signed [epm_pkg::PIX_W-1:0]     rsp_pixel_y_out,
   input logic signed [epm_pkg::LON_OUT_W-1:0] rsp_lon_out,
   input logic signed [epm_pkg::LAT_OUT_W-1:0] rsp_lat_out,
   input logic                                 rsp_valid_res
);

   localparam longint REJ_I = -(longint'(1) << COORD_FRAC_BITS);
   localparam logic signed [epm_pkg::LON_OUT_W-1:0] REJ_LON = epm_pkg::LON_OUT_W'(REJ_I);
   localparam logic signed [epm_pkg::LAT_OUT_W-1:0] REJ_LAT = epm_pkg::LAT_OUT_W'(REJ_I);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_pixel_x_out) && $stable(rsp_lon_out))
      else $error("stalled result changed");

   a_ready_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request refused with empty output");

   a_reject_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_valid_res |->
         (rsp_pixel_x_out == -1 && rsp_pixel_y_out == -1 &&
          rsp_lon_out == 0 && rsp_lat_out == 0) ||
         (rsp_pixel_x_out == 0 && rsp_pixel_y_out == 0 &&
          rsp_lon_out == REJ_LON && rsp_lat_out == REJ_LAT))
      else $error("bad rejection code");

endmodule

bind equirectangular_pixel_map_top epm_checker #(
   .COORD_FRAC_BITS (COORD_FRAC_BITS)
) u_epm_checker (
   .clock           (clock),
   .reset           (reset),
   .req_ready       (req_ready),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_pixel_x_out (rsp_pixel_x_out),
   .rsp_pixel_y_out (rsp_pixel_y_out),
   .rsp_lon_out     (rsp_lon_out),
   .rsp_lat_out     (rsp_lat_out),
   .rsp_valid_res   (rsp_valid_res)
);

>>> dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Equirectangular pixel map testbench
// Drives forward and reverse mapping requests through several corner-box and
// image-size settings, predicts every result and checks it field by field.
// ----------------------------------------------------------------------------

class map_scoreboard;
   typedef struct {
      logic signed [16:0] px;
      logic signed [16:0] py;
      logic signed [25:0] lon;
      logic signed [24:0] lat;
      logic               ok;
   } map_result_type;

   map_result_type pending[$];
   int mismatches;
   int checked;

   longint img_w, img_h, tl_lon, tl_lat, br_lon, br_lat;

   function void set_reg(epm_pkg::csr_index_type idx, logic [24:0] d);
      case (idx)
         epm_pkg::CSR_IMAGE_WIDTH: begin
            img_w = longint'(d[14:0]);
         end
         epm_pkg::CSR_IMAGE_HEIGHT: begin
            img_h = longint'(d[14:0]);
         end
         epm_pkg::CSR_TOP_LEFT_LON: begin
            tl_lon = longint'($signed(d[24:0]));
         end
         epm_pkg::CSR_TOP_LEFT_LAT: begin
            tl_lat = longint'($signed(d[23:0]));
         end
         epm_pkg::CSR_BOTTOM_RIGHT_LON: begin
            br_lon = longint'($signed(d[24:0]));
         end
         epm_pkg::CSR_BOTTOM_RIGHT_LAT: begin
            br_lat = longint'($signed(d[23:0]));
         end
         default: begin
         end
      endcase
   endfunction

   function void reset_regs();
      img_w = 1; img_h = 1;
      tl_lon = -180 * 65536; tl_lat = 90 * 65536;
      br_lon = 180 * 65536; br_lat = -90 * 65536;
   endfunction

   static function longint mag(longint v);
      return v < 0 ? -v : v;
   endfunction

   static function longint sat_pix(longint v);
      if (v < -65536) return -65536;
      if (v > 65535) return 65535;
      return v;
   endfunction

   static function longint scaled_pixel(longint num, longint scale, longint den);
      longint p;
      p = num * scale;
      if (den == 0) return p > 0 ? 65535 : (p < 0 ? -65536 : 0);
      return sat_pix(p / den);
   endfunction

   static function longint floor_div(longint n, longint d);
      longint q;
      q = n / d;
      if ((n % d != 0) && ((n < 0) != (d < 0))) q = q - 1;
      return q;
   endfunction

   function void note_request(logic op, logic signed [24:0] lon_in,
                              logic signed [23:0] lat_in, logic signed [16:0] x_in,
                              logic signed [16:0] y_in, logic oob);
      longint w, h, cl, cn, ol, on, px, py, lo, la, lon, lat, x, y;
      logic ok;
      map_result_type r;
      w = img_w > 16384 ? 16384 : img_w;
      h = img_h > 16384 ? 16384 : img_h;
      cl = mag(tl_lat - br_lat);
      cn = mag(tl_lon - br_lon);
      ol = mag(tl_lat - 90 * 65536);
      on = mag(tl_lon + 180 * 65536);
      px = 0; py = 0; lo = 0; la = 0; ok = 1;
      if (op == epm_pkg::OP_FORWARD) begin
         lon = longint'(lon_in); lat = longint'(lat_in);
         if (!oob && (lat > tl_lat || lat < br_lat || lon < tl_lon || lon > br_lon)) begin
            ok = 0;
         end else begin
            py = scaled_pixel(90 * 65536 - lat - ol, h, cl);
            px = scaled_pixel(lon + 180 * 65536 - on, w, cn);
            if (!oob && (py < 0 || py >= h || px < 0 || px >= w)) ok = 0;
         end
         if (!ok) begin
            px = -1; py = -1;
         end
      end else begin
         x = longint'(x_in); y = longint'(y_in);
         if (y < 0 || y >= h || x < 0 || x >= w) begin
            ok = 0;
         end else begin
            // operands are non-negative here, so truncation equals floor
            la = 90 * 65536 - (floor_div(y * cl, h) + ol);
            lo = floor_div(x * cn, w) + on - 180 * 65536;
            if (la > tl_lat || la < br_lat || lo < tl_lon || lo > br_lon) ok = 0;
         end
         if (!ok) begin
            lo = -65536; la = -65536;
         end
      end
      r.px = 17'(px); r.py = 17'(py); r.lon = 26'(lo); r.lat = 25'(la); r.ok = ok;
      pending.push_back(r);
   endfunction

   function void check_result(logic signed [16:0] px, logic signed [16:0] py,
                              logic signed [25:0] lon, logic signed [24:0] lat,
                              logic ok);
      map_result_type e;
      if (pending.size() == 0) begin
         mismatches++;
         if (mismatches <= 10) $display("unexpected result px=%0d py=%0d", px, py);
         return;
      end
      e = pending.pop_front();
      checked++;
      if (e.px !== px || e.py !== py || e.lon !== lon || e.lat !== lat || e.ok !== ok) begin
         mismatches++;
         if (mismatches <= 10)
            $display("mismatch: exp px=%0d py=%0d lon=%0d lat=%0d ok=%0b got %0d %0d %0d %0d %0b",
                     e.px, e.py, e.lon, e.lat, e.ok, px, py, lon, lat, ok);
      end
   endfunction
endclass

module testbench;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0, req_op = 0, req_allow_out_of_bounds = 0;
   logic signed [epm_pkg::LON_W-1:0] req_lon_in = '0;
   logic signed [epm_pkg::LAT_W-1:0] req_lat_in = '0;
   logic signed [epm_pkg::PIX_W-1:0] req_pixel_x_in = '0, req_pixel_y_in = '0;
   logic req_ready, rsp_valid, rsp_valid_res, csr_ready;
   logic rsp_ready = 0;
   logic signed [epm_pkg::PIX_W-1:0] rsp_pixel_x_out, rsp_pixel_y_out;
   logic signed [epm_pkg::LON_OUT_W-1:0] rsp_lon_out;
   logic signed [epm_pkg::LAT_OUT_W-1:0] rsp_lat_out;
   logic csr_valid = 0;
   epm_pkg::csr_index_type csr_index = epm_pkg::CSR_IMAGE_WIDTH;
   logic [epm_pkg::CSR_DATA_W-1:0] csr_data = '0;

   map_scoreboard board;
   int cycle_count = 0;
   bit steady = 0;
   int n_fwd = 0, n_rev = 0;

   localparam int CYCLE_LIMIT = 400000;

   equirectangular_pixel_map_top dut (.*);

   always begin
      #4 clock = 1;
      #4 clock = 0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("FAIL");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready)
            board.check_result(rsp_pixel_x_out, rsp_pixel_y_out, rsp_lon_out,
                               rsp_lat_out, rsp_valid_res);
         rsp_ready <= steady ? 1'b1 : ($urandom_range(99) >= 38);
      end
   end

   task automatic write_reg(epm_pkg::csr_index_type idx,
                            logic [epm_pkg::CSR_DATA_W-1:0] d);
      csr_valid <= 1; csr_index <= idx; csr_data <= d;
      do @(posedge clock); while (!csr_ready);
      board.set_reg(idx, d);
   endtask

   task automatic send(logic op, logic signed [24:0] lon, logic signed [23:0] lat,
                       logic signed [16:0] x, logic signed [16:0] y, logic oob);
      if (!steady) begin
         while ($urandom_range(99) < 38) begin
            req_valid <= 0;
            @(posedge clock);
         end
      end
      req_valid <= 1; req_op <= op; req_lon_in <= lon; req_lat_in <= lat;
      req_pixel_x_in <= x; req_pixel_y_in <= y; req_allow_out_of_bounds <= oob;
      do @(posedge clock); while (!req_ready);
      board.note_request(op, lon, lat, x, y, oob);
      if (op == epm_pkg::OP_FORWARD) n_fwd++; else n_rev++;
   endtask

   task automatic drain();
      req_valid <= 0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic set_box(int w, int h, int tlon, int tlat, int blon, int blat);
      write_reg(epm_pkg::CSR_IMAGE_WIDTH, epm_pkg::CSR_DATA_W'(w));
      write_reg(epm_pkg::CSR_IMAGE_HEIGHT, epm_pkg::CSR_DATA_W'(h));
      write_reg(epm_pkg::CSR_TOP_LEFT_LON, epm_pkg::CSR_DATA_W'(tlon));
      write_reg(epm_pkg::CSR_TOP_LEFT_LAT, epm_pkg::CSR_DATA_W'(tlat));
      write_reg(epm_pkg::CSR_BOTTOM_RIGHT_LON, epm_pkg::CSR_DATA_W'(blon));
      write_reg(epm_pkg::CSR_BOTTOM_RIGHT_LAT, epm_pkg::CSR_DATA_W'(blat));
      csr_valid <= 0;
   endtask

   task automatic random_burst(int count);
      int k, w, h;
      logic [24:0] lon;
      logic [23:0] lat;
      logic [16:0] x, y;
      w = int'(board.img_w > 16384 ? 16384 : board.img_w);
      h = int'(board.img_h > 16384 ? 16384 : board.img_h);
      for (k = 0; k < count; k++) begin
         case ($urandom_range(3))
            0: begin
               lon = 25'($urandom); lat = 24'($urandom);
               x = 17'($urandom); y = 17'($urandom);
            end
            default: begin
               lon = 25'(board.tl_lon + longint'($urandom_range(1000)) *
                         (board.br_lon - board.tl_lon) / 1000);
               lat = 24'(board.br_lat + longint'($urandom_range(1000)) *
                         (board.tl_lat - board.br_lat) / 1000);
               x = (w > 0) ? 17'($urandom_range(w - 1)) : 17'($urandom);
               y = (h > 0) ? 17'($urandom_range(h - 1)) : 17'($urandom);
            end
         endcase
         send(1'($urandom_range(1)), lon, lat, x, y, $urandom_range(99) < 20);
      end
   endtask

   initial begin
      int ph;
      board = new();
      board.reset_regs();
      repeat (6) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: whole-world image on the reset-default corners, and edge values
      set_box(360, 180, -180 * 65536, 90 * 65536, 180 * 65536, -90 * 65536);
      send(epm_pkg::OP_FORWARD, -11796480, 5898240, 0, 0, 0);
      send(epm_pkg::OP_FORWARD, 11796480, -5898240, 0, 0, 0);
      send(epm_pkg::OP_FORWARD, 0, 0, 0, 0, 0);
      send(epm_pkg::OP_FORWARD, 25'h0FFFFFF, 24'h7FFFFF, 0, 0, 0);
      send(epm_pkg::OP_FORWARD, 25'h1000000, 24'h800000, 0, 0, 1);
      send(epm_pkg::OP_FORWARD, 25'h0FFFFFF, 24'h7FFFFF, 17'h1FFFF, 17'h0FFFF, 1);
      send(epm_pkg::OP_REVERSE, 0, 0, 0, 0, 0);
      send(epm_pkg::OP_REVERSE, 0, 0, 359, 179, 0);
      send(epm_pkg::OP_REVERSE, 0, 0, 360, 180, 0);
      send(epm_pkg::OP_REVERSE, 0, 0, 17'h10000, 17'h10000, 1);
      send(epm_pkg::OP_REVERSE, 0, 0, 17'h0FFFF, 17'h0FFFF, 0);
      send(epm_pkg::OP_REVERSE, 0, 0, -1, 5, 0);
      drain();
      // zero span, zero size
      set_box(0, 0, 10 * 65536, 20 * 65536, 10 * 65536, 20 * 65536);
      send(epm_pkg::OP_FORWARD, 10 * 65536, 20 * 65536, 0, 0, 0);
      send(epm_pkg::OP_FORWARD, 11 * 65536, 19 * 65536, 0, 0, 1);
      send(epm_pkg::OP_FORWARD, 9 * 65536, 21 * 65536, 0, 0, 1);
      send(epm_pkg::OP_FORWARD, 10 * 65536, 20 * 65536, 0, 0, 1);
      send(epm_pkg::OP_REVERSE, 0, 0, 0, 0, 0);
      drain();
      // oversized image, reversed corners
      set_box(32767, 32767, 11796480, -5898240, -11796480, 5898240);
      send(epm_pkg::OP_FORWARD, 0, 0, 0, 0, 1);
      send(epm_pkg::OP_FORWARD, 0, 0, 0, 0, 0);
      send(epm_pkg::OP_REVERSE, 0, 0, 16383, 16383, 0);
      send(epm_pkg::OP_REVERSE, 0, 0, 16384, 0, 0);
      drain();

      for (ph = 0; ph < 7; ph++) begin
         case (ph)
            0: set_box(1, 1, -11796480, 5898240, 11796480, -5898240);
            1: set_box(1024, 512, -30 * 65536, 60 * 65536, 45 * 65536, 10 * 65536);
            2: set_box(16384, 16384, -11796480, 5898240, 11796480, -5898240);
            3: set_box($urandom_range(1, 4000), $urandom_range(1, 4000),
                       -$urandom_range(0, 11796480), $urandom_range(0, 5898240),
                       $urandom_range(0, 11796480), -$urandom_range(0, 5898240));
            4: set_box(7, 3, 5 * 65536 + 123, -2 * 65536, 5 * 65536 + 900, -3 * 65536);
            5: set_box(25'h1FFFFFF, 25'h1FFFFFF, 25'h1FFFFFF, 25'h1FFFFFF,
                       25'h1FFFFFF, 25'h1FFFFFF);
            default: set_box(640, 480, -11796480, 5898240, 11796480, -5898240);
         endcase
         steady = (ph == 2);
         random_burst(250);
         steady = 0;
         drain();
      end

      $display("covered %0d forward and %0d reverse requests over 10 register settings",
               n_fwd, n_rev);
      $display("%0d results checked, %0d mismatches", board.checked, board.mismatches);
      if (board.mismatches == 0 && board.pending.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end
endmodule
